// ----- sv/grouped_three_sample_averager_core_defines.svh -----
// assertion macros for the grouped three-sample averager checker
// no dependencies; expects aclk and aresetn in the scope of use
`ifndef GROUPED_THREE_SAMPLE_AVERAGER_CORE_DEFINES_SVH
`define GROUPED_THREE_SAMPLE_AVERAGER_CORE_DEFINES_SVH

// clocked assertion, switched off while reset is asserted
`define GTSA_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// clocked assertion, also checked during reset
`define GTSA_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) \
        else $error(msg);

`endif

// ----- sv/gtsa_pkg.sv -----
// shared types and constants for the grouped three-sample averager
// no dependencies
package gtsa_pkg;

    localparam int GROUPS        = 5;
    localparam int CHANNELS      = 4;
    localparam int KIND_W        = 3;
    localparam int FILL_W        = 2;
    // quotient bits resolved per divider cycle
    localparam int DIV_STEP_BITS = 4;

    // group codes carried in tuser
    localparam logic [KIND_W-1:0] KIND_ACCEL = 3'd0;
    localparam logic [KIND_W-1:0] KIND_GYRO  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MAG   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_QUAT  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_BARO  = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic capture;   // latch item, start ring read
        logic update;    // write ring, update sums, load divider
        logic div_step;  // one divider iteration
        logic present;   // load output register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic kind_ok;   // incoming kind is a known group
        logic div_done;  // current divider step is the last
        logic out_free;  // output register can take a new item
    } status_t;

    // channels carried by each group
    function automatic logic [CHANNELS-1:0] used_mask(input logic [KIND_W-1:0] kind);
        logic [CHANNELS-1:0] mask;
        case (kind)
            KIND_QUAT: mask = 4'b1111;
            KIND_BARO: mask = 4'b0011;
            default:   mask = 4'b0111;
        endcase
        return mask;
    endfunction

endpackage

// ----- sv/grouped_three_sample_averager_core.sv -----
// top level of the grouped three-sample averager
// depends on gtsa_pkg, gtsa_ctrl, gtsa_datapath (and gtsa_ram below it)
//
//  channel | direction | handshake          | tuser      | tdata (lowest bits first)
//  s_      | in        | s_tvalid/s_tready  | kind       | value_a, value_b, value_c, value_d
//  m_      | out       | m_tvalid/m_tready  | group      | avg_a, avg_b, avg_c, avg_d, fill_count
//
// an item with a known group is captured while its ring row is read, then the ring is
// written and the sums updated, then the iterative divider (four quotient bits a cycle)
// runs, and the result goes to the output register once it is free; only then is the next
// item accepted; an item with an unknown group (5 to 7) is accepted but gives no result
// reset clears the ring row valid bits at once, no clearing pass is needed
// a stalled result holds in the output register; the next item is taken meanwhile
// and only its final output load waits for m_tready
module grouped_three_sample_averager_core #(
    parameter int SAMPLE_BITS = 16,
    parameter int WINDOW      = 3,
    localparam int LANE_W     = gtsa_pkg::CHANNELS * SAMPLE_BITS,
    localparam int S_DATA_W   = ((LANE_W + 7) / 8) * 8,
    localparam int M_DATA_W   = ((LANE_W + gtsa_pkg::FILL_W + 7) / 8) * 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [S_DATA_W-1:0]         s_tdata,   // value_a, value_b, value_c, value_d
    input  logic [gtsa_pkg::KIND_W-1:0] s_tuser,   // kind
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [M_DATA_W-1:0]         m_tdata,   // avg_a, avg_b, avg_c, avg_d, fill_count
    output logic [gtsa_pkg::KIND_W-1:0] m_tuser    // group
);

    gtsa_pkg::cmd_t    cmd;
    gtsa_pkg::status_t status;

    // sequencing
    gtsa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // storage and arithmetic
    gtsa_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .WINDOW      (WINDOW)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

endmodule

// ----- sv/gtsa_ram.sv -----
// generic simple dual-port ram with registered read
// no dependencies
module gtsa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 15,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- sv/gtsa_ctrl.sv -----
// sequencing state machine for the grouped three-sample averager
// depends on gtsa_pkg for the command and status structs
module gtsa_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  gtsa_pkg::status_t status,
    output gtsa_pkg::cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_UPDATE = 2'd1;
    localparam logic [1:0] ST_DIV    = 2'd2;
    localparam logic [1:0] ST_OUT    = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    // unknown groups are dropped here
                    if (status.kind_ok) begin
                        state_next = ST_UPDATE;
                    end
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.present = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- sv/gtsa_datapath.sv -----
// ring store, running sums, divider lanes and output register
// depends on gtsa_pkg and gtsa_ram
module gtsa_datapath #(
    parameter int SAMPLE_BITS = 16,
    parameter int WINDOW      = 3,
    localparam int LANE_W     = gtsa_pkg::CHANNELS * SAMPLE_BITS,
    localparam int S_DATA_W   = ((LANE_W + 7) / 8) * 8,
    localparam int M_DATA_W   = ((LANE_W + gtsa_pkg::FILL_W + 7) / 8) * 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  gtsa_pkg::cmd_t              cmd,
    output gtsa_pkg::status_t           status,
    input  logic [gtsa_pkg::KIND_W-1:0] s_tuser,
    input  logic [S_DATA_W-1:0]         s_tdata,
    input  logic                        m_tready,
    output logic                        m_tvalid,
    output logic [gtsa_pkg::KIND_W-1:0] m_tuser,
    output logic [M_DATA_W-1:0]         m_tdata
);

    localparam int CH      = gtsa_pkg::CHANNELS;
    localparam int NG      = gtsa_pkg::GROUPS;
    localparam int KW      = gtsa_pkg::KIND_W;
    localparam int FW      = gtsa_pkg::FILL_W;
    localparam int STEP    = gtsa_pkg::DIV_STEP_BITS;
    localparam int ROWS    = NG * WINDOW;
    localparam int ROW_W   = $clog2(ROWS);
    localparam int POS_W   = $clog2(WINDOW);
    localparam int CNT_W   = $clog2(WINDOW + 1);
    localparam int SUM_W   = SAMPLE_BITS + $clog2(WINDOW);
    localparam int DIV_CYC = (SUM_W + STEP - 1) / STEP;
    localparam int MAG_W   = DIV_CYC * STEP;
    localparam int DCNT_W  = $clog2(DIV_CYC + 1);

    // item capture
    logic [KW-1:0]                 kind_in;
    logic [KW-1:0]                 kind_idx;
    logic [CH-1:0]                 mask_in;
    logic [ROW_W-1:0]              row_in;
    logic [KW-1:0]                 kind_reg;
    logic signed [SAMPLE_BITS-1:0] in_reg [CH];
    logic [ROW_W-1:0]              row_reg;
    logic                          old_valid_reg;

    // per-group state
    logic [ROWS-1:0]               valid_reg;
    logic [POS_W-1:0]              pos_reg  [NG];
    logic [CNT_W-1:0]              seen_reg [NG];
    logic signed [SUM_W-1:0]       sum_reg  [NG][CH];

    // ring store
    logic [LANE_W-1:0]             ram_wd;
    logic [LANE_W-1:0]             ram_q;

    // update arithmetic
    logic signed [SAMPLE_BITS-1:0] old_val [CH];
    logic signed [SUM_W-1:0]       new_sum [CH];
    logic [SUM_W-1:0]              abs_sum [CH];
    logic [CNT_W-1:0]              seen_next;

    // divider lanes
    logic [MAG_W-1:0]              mag_reg  [CH];
    logic [CNT_W-1:0]              rem_reg  [CH];
    logic [CH-1:0]                 neg_reg;
    logic [CNT_W-1:0]              divisor_reg;
    logic [DCNT_W-1:0]             dcnt_reg;
    logic [MAG_W-1:0]              mag_step [CH];
    logic [CNT_W-1:0]              rem_step [CH];

    // output register
    logic                          m_valid_reg;
    logic [KW-1:0]                 m_group_reg;
    logic [SAMPLE_BITS-1:0]        m_avg_reg [CH];
    logic [FW-1:0]                 m_fill_reg;
    logic [SAMPLE_BITS-1:0]        avg_val [CH];

    // incoming group and ring row
    assign kind_in  = s_tuser;
    assign kind_idx = status.kind_ok ? kind_in : '0;
    assign mask_in  = gtsa_pkg::used_mask(kind_in);
    assign row_in   = ROW_W'(kind_idx * WINDOW) + ROW_W'(pos_reg[kind_idx]);

    // status back to the controller
    assign status.kind_ok  = (kind_in < KW'(NG));
    assign status.div_done = (dcnt_reg == DCNT_W'(DIV_CYC - 1));
    assign status.out_free = !m_valid_reg || m_tready;

    // capture item, unused channels stored as zero
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg      <= kind_in;
            row_reg       <= row_in;
            old_valid_reg <= valid_reg[row_in];
            for (int c = 0; c < CH; c++) begin
                in_reg[c] <= mask_in[c] ? s_tdata[c*SAMPLE_BITS +: SAMPLE_BITS] : '0;
            end
        end
    end

    gtsa_ram #(
        .WIDTH (LANE_W),
        .DEPTH (ROWS)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (cmd.update),
        .wr_addr (row_reg),
        .wr_data (ram_wd),
        .rd_en   (cmd.capture),
        .rd_addr (row_in),
        .rd_data (ram_q)
    );

    // new sums: add the new sample, drop the one it overwrites
    always_comb begin
        for (int c = 0; c < CH; c++) begin
            ram_wd[c*SAMPLE_BITS +: SAMPLE_BITS] = in_reg[c];
            old_val[c] = old_valid_reg ? $signed(ram_q[c*SAMPLE_BITS +: SAMPLE_BITS]) : '0;
            new_sum[c] = sum_reg[kind_reg][c] - SUM_W'(old_val[c]) + SUM_W'(in_reg[c]);
            abs_sum[c] = new_sum[c][SUM_W-1] ? SUM_W'(-new_sum[c]) : SUM_W'(new_sum[c]);
        end
        seen_next = (seen_reg[kind_reg] == CNT_W'(WINDOW)) ? seen_reg[kind_reg]
                                                           : seen_reg[kind_reg] + 1'b1;
    end

    // per-group state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            for (int g = 0; g < NG; g++) begin
                pos_reg[g]  <= '0;
                seen_reg[g] <= '0;
                for (int c = 0; c < CH; c++) begin
                    sum_reg[g][c] <= '0;
                end
            end
        end else if (cmd.update) begin
            valid_reg[row_reg] <= 1'b1;
            seen_reg[kind_reg] <= seen_next;
            pos_reg[kind_reg]  <= (pos_reg[kind_reg] == POS_W'(WINDOW - 1)) ? '0
                                  : pos_reg[kind_reg] + 1'b1;
            for (int c = 0; c < CH; c++) begin
                sum_reg[kind_reg][c] <= new_sum[c];
            end
        end
    end

    // restoring division of the magnitudes, STEP quotient bits per cycle
    always_comb begin
        logic [MAG_W-1:0] m;
        logic [CNT_W-1:0] r;
        logic [CNT_W:0]   t;
        for (int c = 0; c < CH; c++) begin
            m = mag_reg[c];
            r = rem_reg[c];
            for (int i = 0; i < STEP; i++) begin
                t = {r, m[MAG_W-1]};
                m = {m[MAG_W-2:0], 1'b0};
                if (t >= {1'b0, divisor_reg}) begin
                    t    = t - {1'b0, divisor_reg};
                    m[0] = 1'b1;
                end
                r = t[CNT_W-1:0];
            end
            mag_step[c] = m;
            rem_step[c] = r;
        end
    end

    // divider registers
    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            divisor_reg <= seen_next;
            dcnt_reg    <= '0;
            for (int c = 0; c < CH; c++) begin
                neg_reg[c] <= new_sum[c][SUM_W-1];
                mag_reg[c] <= MAG_W'(abs_sum[c]);
                rem_reg[c] <= '0;
            end
        end else if (cmd.div_step) begin
            dcnt_reg <= dcnt_reg + 1'b1;
            for (int c = 0; c < CH; c++) begin
                mag_reg[c] <= mag_step[c];
                rem_reg[c] <= rem_step[c];
            end
        end
    end

    // sign restore, truncation toward zero
    always_comb begin
        for (int c = 0; c < CH; c++) begin
            avg_val[c] = neg_reg[c] ? -mag_reg[c][SAMPLE_BITS-1:0] : mag_reg[c][SAMPLE_BITS-1:0];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.present) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.present) begin
            m_group_reg <= kind_reg;
            m_fill_reg  <= FW'(divisor_reg);
            for (int c = 0; c < CH; c++) begin
                m_avg_reg[c] <= avg_val[c];
            end
        end
    end

    // result packing
    always_comb begin
        m_tdata = '0;
        for (int c = 0; c < CH; c++) begin
            m_tdata[c*SAMPLE_BITS +: SAMPLE_BITS] = m_avg_reg[c];
        end
        m_tdata[LANE_W +: FW] = m_fill_reg;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_group_reg;

endmodule

// ----- sv/gtsa_checker.sv -----
// port-level assertions for the grouped three-sample averager, bound to the top
// depends on gtsa_pkg and grouped_three_sample_averager_core_defines.svh
`include "grouped_three_sample_averager_core_defines.svh"

module gtsa_checker #(
    parameter int SAMPLE_BITS = 16,
    parameter int WINDOW      = 3,
    localparam int LANE_W     = gtsa_pkg::CHANNELS * SAMPLE_BITS,
    localparam int M_DATA_W   = ((LANE_W + gtsa_pkg::FILL_W + 7) / 8) * 8
) (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [M_DATA_W-1:0]         m_tdata,
    input logic [gtsa_pkg::KIND_W-1:0] m_tuser
);

    // a result waiting on the sink stays put
    `GTSA_ASSERT_RST(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // no result right after reset
    `GTSA_ASSERT_CLK(a_reset_idle, !aresetn |=> !m_tvalid, "result shown after reset")

    // divisor is never zero and never above the window
    `GTSA_ASSERT_RST(a_fill_range, m_tvalid |-> m_tdata[LANE_W +: gtsa_pkg::FILL_W] != '0 && m_tdata[LANE_W +: gtsa_pkg::FILL_W] <= gtsa_pkg::FILL_W'(WINDOW), "fill count out of range")

    // barometer group carries only two channels
    `GTSA_ASSERT_RST(a_baro_unused, m_tvalid && m_tuser == gtsa_pkg::KIND_BARO |-> m_tdata[2*SAMPLE_BITS +: 2*SAMPLE_BITS] == '0, "unused barometer channel not zero")

    // fourth channel only for the quaternion group
    `GTSA_ASSERT_RST(a_fourth_unused, m_tvalid && m_tuser != gtsa_pkg::KIND_QUAT |-> m_tdata[3*SAMPLE_BITS +: SAMPLE_BITS] == '0, "fourth channel not zero")

endmodule

bind grouped_three_sample_averager_core gtsa_checker #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .WINDOW      (WINDOW)
) u_gtsa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
